// ----- design/lfs_pkg.sv -----
// Shared types and constants for the line follower steering block.
// No dependencies; imported by lfs_ctrl, lfs_dp and line_follow_steering.
`default_nettype none

package lfs_pkg;

  // Wheel direction codes on the result channel
  typedef enum logic [1:0] {
    WHEEL_STOP = 2'd0,
    WHEEL_FWD  = 2'd1,
    WHEEL_BACK = 2'd2
  } wheel_t;

  // Turn direction codes kept in the history ring
  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2
  } turn_t;

  // What one sample asks for after classification
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_SPIN = 2'd2
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_EVAL = 3'd1,
    S_SCAN = 3'd2,
    S_SPIN = 3'd3,
    S_MUL  = 3'd4,
    S_OUT  = 3'd5
  } state_t;

  // Widths
  localparam int SPEED_W = 10;
  localparam int LIMIT_W = 8;
  localparam int GAIN_W  = 9;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = SPEED_W + GAIN_W;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_BASE_SPEED  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_TURN_SPEED  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_SLOW_SPEED  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_SPIN_SPEED  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_SHARP_SPEED = 3'd4;
  localparam logic [IDX_W-1:0] CFG_LOST_LIMIT  = 3'd5;
  localparam logic [IDX_W-1:0] CFG_LEFT_GAIN   = 3'd6;

  // Register reset values
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 10'd700;
  localparam logic [SPEED_W-1:0] TURN_SPEED_RST  = 10'd500;
  localparam logic [SPEED_W-1:0] SLOW_SPEED_RST  = 10'd500;
  localparam logic [SPEED_W-1:0] SPIN_SPEED_RST  = 10'd600;
  localparam logic [SPEED_W-1:0] SHARP_SPEED_RST = 10'd600;
  localparam logic [LIMIT_W-1:0] LOST_LIMIT_RST  = 8'd5;
  localparam logic [GAIN_W-1:0]  LEFT_GAIN_RST   = 9'd269;

  localparam logic [SPEED_W-1:0] DUTY_MAX = 10'd1000;
  localparam logic [LIMIT_W-1:0] LOST_MAX = 8'd255;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture the sensor sample
    logic eval;      // classify, update lost count and ring, load command
    logic scan_step; // count one history entry
    logic set_spin;  // pick spin direction from the counts
    logic mul;       // register the left gain product
    logic emit;      // load the result register
  } lfs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    kind_t kind;
    logic  scan_last;
    logic  out_free;
  } lfs_sts_t;

endpackage

`default_nettype wire

// ----- design/lfs_if.sv -----
// Valid/ready channel interfaces for sensor samples and motor commands.
// Depends on nothing.
`default_nettype none

interface lfs_in_if;
  logic valid;
  logic ready;
  logic sensor_left;
  logic sensor_mid_left;
  logic sensor_mid_right;
  logic sensor_right;

  modport source (output valid, output sensor_left, output sensor_mid_left,
                  output sensor_mid_right, output sensor_right, input ready);
  modport sink (input valid, input sensor_left, input sensor_mid_left,
                input sensor_mid_right, input sensor_right, output ready);
endinterface

interface lfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] left_dir;
  logic [1:0] right_dir;
  logic [9:0] left_duty;
  logic [9:0] right_duty;
  logic       cross_hold;

  modport source (output valid, output left_dir, output right_dir, output left_duty,
                  output right_duty, output cross_hold, input ready);
  modport sink (input valid, input left_dir, input right_dir, input left_duty,
                input right_duty, input cross_hold, output ready);
endinterface

`default_nettype wire

// ----- design/lfs_ctrl.sv -----
// Sequencing state machine for the steering block.
// Depends on lfs_pkg; drives lfs_dp through lfs_cmd_t and reads lfs_sts_t.
`default_nettype none

module lfs_ctrl
  import lfs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lfs_sts_t sts,
  output lfs_cmd_t      cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        unique case (sts.kind)
          KIND_SPIN: state_nxt = S_SCAN;
          KIND_CMD:  state_nxt = S_MUL;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_SPIN;
      end
      S_SPIN: begin
        cmd.set_spin = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the result register can take the item
        cmd.emit = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/lfs_dp.sv -----
// Datapath: configuration registers, pattern decode, lost counter, history
// ring with serial majority count, left gain multiply and result register.
// Depends on lfs_pkg and lfs_out_if; commanded by lfs_ctrl.
`default_nettype none

module lfs_dp
  import lfs_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_idx,
  input  wire logic [SPEED_W-1:0] cfg_data,
  input  wire logic [3:0]         sensors,
  input  wire lfs_cmd_t           cmd,
  output lfs_sts_t                sts,
  lfs_out_if.source               out_ch
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

  // Configuration registers
  logic [SPEED_W-1:0] base_speed_r, turn_speed_r, slow_speed_r, spin_speed_r, sharp_speed_r;
  logic [LIMIT_W-1:0] lost_limit_r;
  logic [GAIN_W-1:0]  left_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r  <= BASE_SPEED_RST;
      turn_speed_r  <= TURN_SPEED_RST;
      slow_speed_r  <= SLOW_SPEED_RST;
      spin_speed_r  <= SPIN_SPEED_RST;
      sharp_speed_r <= SHARP_SPEED_RST;
      lost_limit_r  <= LOST_LIMIT_RST;
      left_gain_r   <= LEFT_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BASE_SPEED:  base_speed_r  <= cfg_data;
        CFG_TURN_SPEED:  turn_speed_r  <= cfg_data;
        CFG_SLOW_SPEED:  slow_speed_r  <= cfg_data;
        CFG_SPIN_SPEED:  spin_speed_r  <= cfg_data;
        CFG_SHARP_SPEED: sharp_speed_r <= cfg_data;
        CFG_LOST_LIMIT:  lost_limit_r  <= cfg_data[LIMIT_W-1:0];
        CFG_LEFT_GAIN:   left_gain_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample register
  logic [3:0] sensor_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) sensor_r <= sensors;
  end

  logic l, ml, mr, r;
  assign {l, ml, mr, r} = sensor_r;

  // Machine state
  logic [LIMIT_W-1:0] lost_count_r;
  logic [1:0]         hist_r [HISTORY_DEPTH];
  logic [PTR_W-1:0]   ptr_r;
  turn_t              last_dir_r;

  // Decode the sample
  logic               any_lit;
  logic [LIMIT_W-1:0] lost_inc;
  kind_t              kind;
  wheel_t             c_ldir, c_rdir;
  logic [SPEED_W-1:0] c_lspeed, c_rspeed;
  logic               c_lzero, c_rzero, c_hold, rec_en;
  turn_t              rec_dir;

  always_comb begin
    any_lit  = l | ml | mr | r;
    lost_inc = (lost_count_r < LOST_MAX) ? lost_count_r + 1'b1 : lost_count_r;
    kind     = KIND_CMD;
    c_ldir   = WHEEL_FWD;
    c_rdir   = WHEEL_FWD;
    c_lspeed = base_speed_r;
    c_rspeed = base_speed_r;
    c_lzero  = 1'b0;
    c_rzero  = 1'b0;
    c_hold   = 1'b0;
    rec_en   = 1'b0;
    rec_dir  = TURN_LEFT;
    if (!any_lit) begin
      // lost line: spin once the limit is passed, direction set after the scan
      kind     = (lost_inc > lost_limit_r) ? KIND_SPIN : KIND_NONE;
      c_ldir   = WHEEL_BACK;
      c_lspeed = spin_speed_r;
      c_rspeed = spin_speed_r;
    end else if (l && ml && mr && r) begin
      c_lspeed = slow_speed_r;
      c_rspeed = slow_speed_r;
      c_hold   = 1'b1;
    end else if (l && (ml || mr)) begin
      c_ldir   = WHEEL_STOP;
      c_lzero  = 1'b1;
      c_rspeed = turn_speed_r;
      rec_en   = 1'b1;
    end else if (r && (ml || mr)) begin
      c_rdir   = WHEEL_STOP;
      c_rzero  = 1'b1;
      c_lspeed = turn_speed_r;
      rec_en   = 1'b1;
      rec_dir  = TURN_RIGHT;
    end else if (ml && mr) begin
      // straight run keeps the base speed defaults
    end else if (ml) begin
      c_lspeed = turn_speed_r;
      rec_en   = 1'b1;
    end else if (mr) begin
      c_rspeed = turn_speed_r;
      rec_en   = 1'b1;
      rec_dir  = TURN_RIGHT;
    end else if (l && !r) begin
      c_ldir   = WHEEL_BACK;
      c_lspeed = sharp_speed_r;
      c_rspeed = sharp_speed_r;
      rec_en   = 1'b1;
    end else if (r && !l) begin
      c_rdir   = WHEEL_BACK;
      c_lspeed = sharp_speed_r;
      c_rspeed = sharp_speed_r;
      rec_en   = 1'b1;
      rec_dir  = TURN_RIGHT;
    end else begin
      // both outer sensors only
      kind = KIND_NONE;
    end
  end

  // Lost counter, history ring and last direction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lost_count_r <= '0;
      ptr_r        <= '0;
      last_dir_r   <= TURN_NONE;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_r[i] <= TURN_NONE;
    end else if (cmd.eval) begin
      lost_count_r <= any_lit ? '0 : lost_inc;
      if (rec_en) begin
        hist_r[ptr_r] <= rec_dir;
        ptr_r         <= (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
        last_dir_r    <= rec_dir;
      end
    end
  end

  // Serial majority count over the ring, one entry per cycle
  logic [PTR_W-1:0] scan_idx_r;
  logic [CNT_W-1:0] n_left_r, n_right_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      scan_idx_r <= '0;
      n_left_r   <= '0;
      n_right_r  <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (hist_r[scan_idx_r] == TURN_LEFT)  n_left_r  <= n_left_r + 1'b1;
      if (hist_r[scan_idx_r] == TURN_RIGHT) n_right_r <= n_right_r + 1'b1;
    end
  end

  // Command registers
  wheel_t             ldir_r, rdir_r;
  logic [SPEED_W-1:0] lspeed_r, rduty_r;
  logic               lzero_r, hold_r;
  logic               spin_right;

  always_comb begin
    if (n_left_r > n_right_r)      spin_right = 1'b0;
    else if (n_right_r > n_left_r) spin_right = 1'b1;
    else                           spin_right = (last_dir_r == TURN_RIGHT);
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ldir_r   <= c_ldir;
      rdir_r   <= c_rdir;
      lspeed_r <= c_lspeed;
      lzero_r  <= c_lzero;
      hold_r   <= c_hold;
      rduty_r  <= c_rzero ? '0 : ((c_rspeed > DUTY_MAX) ? DUTY_MAX : c_rspeed);
    end else if (cmd.set_spin) begin
      ldir_r <= spin_right ? WHEEL_FWD : WHEEL_BACK;
      rdir_r <= spin_right ? WHEEL_BACK : WHEEL_FWD;
    end
  end

  // Left gain product, Q1.8
  logic [PROD_W-1:0] prod_r;
  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= lspeed_r * left_gain_r;
  end

  // Saturate the scaled left duty
  logic [PROD_W-9:0]  scaled;
  logic [SPEED_W-1:0] lduty;
  always_comb begin
    scaled = prod_r[PROD_W-1:8];
    if (lzero_r)                                    lduty = '0;
    else if (scaled > {1'b0, DUTY_MAX})             lduty = DUTY_MAX;
    else                                            lduty = scaled[SPEED_W-1:0];
  end

  // Result register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [1:0]         o_ldir_r, o_rdir_r;
  logic [SPEED_W-1:0] o_lduty_r, o_rduty_r;
  logic               o_hold_r;
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_ldir_r  <= ldir_r;
      o_rdir_r  <= rdir_r;
      o_lduty_r <= lduty;
      o_rduty_r <= rduty_r;
      o_hold_r  <= hold_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.left_dir   = o_ldir_r;
  assign out_ch.right_dir  = o_rdir_r;
  assign out_ch.left_duty  = o_lduty_r;
  assign out_ch.right_duty = o_rduty_r;
  assign out_ch.cross_hold = o_hold_r;

  // Status
  assign sts.kind      = kind;
  assign sts.scan_last = (scan_idx_r == PTR_LAST);
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  // Checks
  a_lost_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval && any_lit |=> lost_count_r == '0)
    else $error("lost counter not cleared by a lit sample");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_LAST)
    else $error("history pointer out of range");

  a_cross_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_hold_r |-> o_ldir_r == WHEEL_FWD && o_rdir_r == WHEEL_FWD)
    else $error("crossroad hold without both wheels forward");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted item not presented");

endmodule

`default_nettype wire

// ----- design/line_follow_steering.sv -----
// Top level of the four-sensor line follower steering block.
// Depends on lfs_pkg, lfs_if, lfs_ctrl and lfs_dp.
//
// Each accepted item is one sensor sample; it yields one motor command or
// none. A sample that gives a direct command passes from acceptance
// through decode, gain multiply and output load before the next item can be
// accepted. A sample that gives no result is only accepted and decoded. A
// lost-line spin adds a history scan, one entry per cycle through a single
// read port, and a spin direction step. A finished command waits in an output
// register, so the next sample is taken while the previous command is still
// unread; a new command stalls in the last step only when that register is
// still occupied. Configuration writes go straight into the registers.
`default_nettype none

module line_follow_steering
  import lfs_pkg::*;
#(
  parameter int HISTORY_DEPTH = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_idx,
  input  wire logic [SPEED_W-1:0] cfg_data,
  lfs_in_if.sink                  in_ch,
  lfs_out_if.source               out_ch
);

  lfs_cmd_t cmd;
  lfs_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  lfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lfs_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .sensors  ({in_ch.sensor_left, in_ch.sensor_mid_left,
                in_ch.sensor_mid_right, in_ch.sensor_right}),
    .cmd      (cmd),
    .sts      (sts),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
